>>> rtl/window_trend_detector_core_assert.svh
// Assertion macros used by wtd_back
`ifndef WINDOW_TREND_DETECTOR_CORE_ASSERT_SVH
`define WINDOW_TREND_DETECTOR_CORE_ASSERT_SVH

// Check a condition at every rising clock edge outside reset
`define WTD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// Check that a condition holds in the cycle after a trigger
`define WTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

>>> rtl/wtd_pkg.sv
package wtd_pkg;

   // window depth default, fixed field widths and queue depth
   localparam int WTD_WINDOW      = 50;
   localparam int WTD_SAMPLE_W    = 16;
   localparam int WTD_FRAC_W      = 17;
   localparam int WTD_FILL_W      = 6;
   localparam int WTD_QUEUE_DEPTH = 2;
   // one integer step plus sixteen fraction steps
   localparam int WTD_DIV_STEPS   = 17;

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [WTD_SAMPLE_W-1:0] relevance;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_head_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> rtl/wtd_front.sv
module wtd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [wtd_pkg::WTD_SAMPLE_W-1:0] req_relevance,
   input  logic                           q_full,
   output wtd_pkg::q_push_type            q_push
);
   import wtd_pkg::*;

   logic      stage_vld_ff, stage_vld_in;
   entry_type stage_ff, stage_in;
   logic      accept;
   logic      push;

   // hand the staged word on when the queue has room
   assign push      = stage_vld_ff && !q_full;
   assign req_stall = stage_vld_ff && q_full;
   assign accept    = req_valid && !req_stall;

   // classify the incoming word and stage it
   always_comb begin
      stage_vld_in = stage_vld_ff;
      stage_in     = stage_ff;
      if (accept) begin
         stage_vld_in       = 1'b1;
         stage_in.op        = req_command ? OP_CLEAR : OP_PUSH;
         stage_in.relevance = req_relevance;
      end else if (push) begin
         stage_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
      stage_ff <= stage_in;
   end

   assign q_push.push  = push;
   assign q_push.entry = stage_ff;

endmodule

>>> rtl/wtd_queue.sv
module wtd_queue (
   input  logic                clock,
   input  logic                reset,
   input  wtd_pkg::q_push_type q_push,
   output logic                q_full,
   input  logic                q_pop,
   output wtd_pkg::q_head_type q_head
);
   import wtd_pkg::*;

   localparam int QP_W = $clog2(WTD_QUEUE_DEPTH);
   localparam int QC_W = $clog2(WTD_QUEUE_DEPTH + 1);

   entry_type         q_mem [WTD_QUEUE_DEPTH];
   logic [QP_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign q_full       = (count_ff == QC_W'(WTD_QUEUE_DEPTH));
   assign q_head.valid = (count_ff != '0);
   assign q_head.entry = q_mem[rd_ptr_ff];
   assign do_push      = q_push.push && !q_full;
   assign do_pop       = q_pop && q_head.valid;

   // advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(WTD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(WTD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         q_mem[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

>>> rtl/wtd_div.sv
module wtd_div #(
   parameter int CNT_W = $clog2(wtd_pkg::WTD_WINDOW + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [CNT_W-1:0]              num,
   input  logic [CNT_W-1:0]              den,
   output wtd_pkg::div_status_type       status,
   output logic [wtd_pkg::WTD_FRAC_W-1:0] quot
);
   import wtd_pkg::*;

   localparam int STEP_W = $clog2(WTD_DIV_STEPS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CNT_W:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]      den_ff, den_in;
   logic                  zero_ff, zero_in;
   logic [WTD_FRAC_W-1:0] q_ff, q_in;
   logic [CNT_W:0]        trial;
   logic                  fit;

   // first step keeps the remainder as is, later steps double it
   assign trial = (step_ff == STEP_W'(WTD_DIV_STEPS)) ? rem_ff : {rem_ff[CNT_W-1:0], 1'b0};
   assign fit   = (trial >= {1'b0, den_ff});

   // restoring division, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      zero_in = zero_ff;
      q_in    = q_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = STEP_W'(WTD_DIV_STEPS);
         rem_in  = {1'b0, num};
         den_in  = den;
         zero_in = (den == '0);
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in  = fit ? trial - {1'b0, den_ff} : trial;
         q_in    = {q_ff[WTD_FRAC_W-2:0], fit};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      zero_ff <= zero_in;
      q_ff    <= q_in;
   end

   // a zero denominator reads as zero
   assign quot        = zero_ff ? '0 : q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> rtl/wtd_back.sv
`include "window_trend_detector_core_assert.svh"

module wtd_back #(
   parameter int WINDOW = wtd_pkg::WTD_WINDOW
) (
   input  logic                           clock,
   input  logic                           reset,
   input  wtd_pkg::q_head_type            q_head,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [wtd_pkg::WTD_FRAC_W-1:0] rsp_rise_fraction,
   output logic [wtd_pkg::WTD_FRAC_W-1:0] rsp_fall_fraction,
   output logic [wtd_pkg::WTD_FRAC_W-1:0] rsp_turn_fraction,
   output logic [wtd_pkg::WTD_FILL_W-1:0] rsp_window_fill
);
   import wtd_pkg::*;

   localparam int PTR_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [CNT_W:0]   WIN_X   = (CNT_W + 1)'(WINDOW);
   localparam logic [CNT_W-1:0] WIN_C   = CNT_W'(WINDOW);
   localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(WINDOW - 1);

   localparam logic [1:0] SEL_RISE = 2'd0;
   localparam logic [1:0] SEL_FALL = 2'd1;
   localparam logic [1:0] SEL_TURN = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SCAN    = 5'b00010,
      S_DIVGO   = 5'b00100,
      S_DIVWAIT = 5'b01000,
      S_OUT     = 5'b10000
   } state_type;

   logic [WTD_SAMPLE_W-1:0] ring_mem [WINDOW];

   state_type               state_ff, state_in;
   logic [PTR_W-1:0]        wp_ff, wp_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [PTR_W-1:0]        rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]        issue_ff, issue_in;
   logic                    rd_vld_ff;
   logic [WTD_SAMPLE_W-1:0] rd_data_ff;
   logic [WTD_SAMPLE_W-1:0] prev_ff, prev_in;
   logic                    have1_ff, have1_in;
   logic                    have2_ff, have2_in;
   logic                    prev_up_ff, prev_up_in;
   logic                    prev_dn_ff, prev_dn_in;
   logic [CNT_W-1:0]        rise_ff, rise_in;
   logic [CNT_W-1:0]        fall_ff, fall_in;
   logic [CNT_W-1:0]        turn_ff, turn_in;
   logic [1:0]              sel_ff, sel_in;
   logic [WTD_FRAC_W-1:0]   rise_q_ff, rise_q_in;
   logic [WTD_FRAC_W-1:0]   fall_q_ff, fall_q_in;
   logic [WTD_FRAC_W-1:0]   turn_q_ff, turn_q_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WTD_FRAC_W-1:0]   rsp_rise_ff, rsp_rise_in;
   logic [WTD_FRAC_W-1:0]   rsp_fall_ff, rsp_fall_in;
   logic [WTD_FRAC_W-1:0]   rsp_turn_ff, rsp_turn_in;
   logic [WTD_FILL_W-1:0]   rsp_fill_ff, rsp_fill_in;

   logic                    wr_en;
   logic                    rd_en;
   logic                    step_up, step_dn;
   logic [CNT_W:0]          oldest;
   logic [CNT_W-1:0]        den_pair, den_turn;
   logic                    div_start;
   logic [CNT_W-1:0]        div_num, div_den;
   div_status_type          div_stat;
   logic [WTD_FRAC_W-1:0]   div_quot;

   assign q_pop   = (state_ff == S_IDLE) && q_head.valid;
   assign wr_en   = q_pop && (q_head.entry.op == OP_PUSH);
   assign rd_en   = (state_ff == S_SCAN) && (issue_ff < fill_ff);
   assign step_up = rd_data_ff > prev_ff;
   assign step_dn = rd_data_ff < prev_ff;

   // denominators: pairs and interior points
   assign den_pair = (fill_ff >= CNT_W'(2)) ? fill_ff - CNT_W'(1) : '0;
   assign den_turn = (fill_ff >= CNT_W'(3)) ? fill_ff - CNT_W'(2) : '0;

   // pick operands for the shared divider
   always_comb begin
      div_start = (state_ff == S_DIVGO);
      unique case (sel_ff)
         SEL_RISE: begin
            div_num = rise_ff;
            div_den = den_pair;
         end
         SEL_FALL: begin
            div_num = fall_ff;
            div_den = den_pair;
         end
         default: begin
            div_num = turn_ff;
            div_den = den_turn;
         end
      endcase
   end

   // sequence: apply word, scan window, divide three times, deliver
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      rd_addr_in   = rd_addr_ff;
      issue_in     = issue_ff;
      prev_in      = prev_ff;
      have1_in     = have1_ff;
      have2_in     = have2_ff;
      prev_up_in   = prev_up_ff;
      prev_dn_in   = prev_dn_ff;
      rise_in      = rise_ff;
      fall_in      = fall_ff;
      turn_in      = turn_ff;
      sel_in       = sel_ff;
      rise_q_in    = rise_q_ff;
      fall_q_in    = fall_q_ff;
      turn_q_in    = turn_q_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rise_in  = rsp_rise_ff;
      rsp_fall_in  = rsp_fall_ff;
      rsp_turn_in  = rsp_turn_ff;
      rsp_fill_in  = rsp_fill_ff;
      oldest       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               if (q_head.entry.op == OP_CLEAR) begin
                  wp_in   = '0;
                  fill_in = '0;
               end else begin
                  wp_in   = (wp_ff == PTR_TOP) ? '0 : wp_ff + 1'b1;
                  fill_in = (fill_ff == WIN_C) ? fill_ff : fill_ff + 1'b1;
               end
               // oldest slot of the window after this word
               oldest = (CNT_W + 1)'(wp_in) + WIN_X - (CNT_W + 1)'(fill_in);
               if (oldest >= WIN_X) begin
                  oldest = oldest - WIN_X;
               end
               rd_addr_in = PTR_W'(oldest);
               issue_in   = '0;
               have1_in   = 1'b0;
               have2_in   = 1'b0;
               prev_up_in = 1'b0;
               prev_dn_in = 1'b0;
               rise_in    = '0;
               fall_in    = '0;
               turn_in    = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               rd_addr_in = (rd_addr_ff == PTR_TOP) ? '0 : rd_addr_ff + 1'b1;
               issue_in   = issue_ff + 1'b1;
            end
            // count steps and turns, oldest to newest
            if (rd_vld_ff) begin
               if (have1_ff) begin
                  if (step_up) begin
                     rise_in = rise_ff + 1'b1;
                  end else if (step_dn) begin
                     fall_in = fall_ff + 1'b1;
                  end
                  prev_up_in = step_up;
                  prev_dn_in = step_dn;
                  have2_in   = 1'b1;
               end
               if (have2_ff && ((prev_up_ff && step_dn) || (prev_dn_ff && step_up))) begin
                  turn_in = turn_ff + 1'b1;
               end
               prev_in  = rd_data_ff;
               have1_in = 1'b1;
            end
            if (!rd_en && !rd_vld_ff) begin
               sel_in   = SEL_RISE;
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_stat.done) begin
               unique case (sel_ff)
                  SEL_RISE: rise_q_in = div_quot;
                  SEL_FALL: fall_q_in = div_quot;
                  default:  turn_q_in = div_quot;
               endcase
               if (sel_ff == SEL_TURN) begin
                  state_in = S_OUT;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = S_DIVGO;
               end
            end
         end
         S_OUT: begin
            // load the output register once the previous word is taken
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_rise_in  = rise_q_ff;
               rsp_fall_in  = fall_q_ff;
               rsp_turn_in  = turn_q_ff;
               rsp_fill_in  = WTD_FILL_W'(fill_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         turn_ff      <= '0;
         sel_ff       <= SEL_RISE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_en;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         turn_ff      <= turn_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff  <= rd_addr_in;
      prev_ff     <= prev_in;
      have1_ff    <= have1_in;
      have2_ff    <= have2_in;
      prev_up_ff  <= prev_up_in;
      prev_dn_ff  <= prev_dn_in;
      rise_q_ff   <= rise_q_in;
      fall_q_ff   <= fall_q_in;
      turn_q_ff   <= turn_q_in;
      rsp_rise_ff <= rsp_rise_in;
      rsp_fall_ff <= rsp_fall_in;
      rsp_turn_ff <= rsp_turn_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   // sample ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wp_ff] <= q_head.entry.relevance;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr_ff];
      end
   end

   wtd_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_stat),
      .quot   (div_quot)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rise_fraction = rsp_rise_ff;
   assign rsp_fall_fraction = rsp_fall_ff;
   assign rsp_turn_fraction = rsp_turn_ff;
   assign rsp_window_fill   = rsp_fill_ff;

   `WTD_ASSERT(a_fill_bound, clock, reset, fill_ff <= WIN_C)
   `WTD_ASSERT(a_scan_issue, clock, reset, !(state_ff == S_SCAN) || (issue_ff <= fill_ff))
   `WTD_ASSERT(a_div_idle_start, clock, reset, !div_start || !div_stat.busy)
   `WTD_ASSERT(a_div_done_wait, clock, reset, !div_stat.done || (state_ff == S_DIVWAIT))
   `WTD_ASSERT_NEXT(a_pop_scan, clock, reset, q_pop, state_ff == S_SCAN)

endmodule

>>> rtl/window_trend_detector_core.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_command, req_relevance
// rsp       out        rsp_valid/rsp_stall   rsp_rise/fall/turn_fraction, rsp_window_fill
//
// A word holds the back end while it is applied, while the ring is scanned through its
// single read port, for each of three quotients (start, 17 divider steps, done) and while
// the output is loaded; the default window holds 50 samples.
// Each word passes the front stage register and the queue before the back end takes it.
// Reset is synchronous and clears control state; the sample ring needs no clearing.
// The queue takes new words while the back end works; rsp_stall holds the output word.
module window_trend_detector_core #(
   parameter int WINDOW = wtd_pkg::WTD_WINDOW
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [wtd_pkg::WTD_SAMPLE_W-1:0] req_relevance,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [wtd_pkg::WTD_FRAC_W-1:0]   rsp_rise_fraction,
   output logic [wtd_pkg::WTD_FRAC_W-1:0]   rsp_fall_fraction,
   output logic [wtd_pkg::WTD_FRAC_W-1:0]   rsp_turn_fraction,
   output logic [wtd_pkg::WTD_FILL_W-1:0]   rsp_window_fill
);
   import wtd_pkg::*;

   q_push_type q_push;
   q_head_type q_head;
   logic       q_full;
   logic       q_pop;

   wtd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_relevance (req_relevance),
      .q_full        (q_full),
      .q_push        (q_push)
   );

   wtd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_head (q_head)
   );

   wtd_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rise_fraction (rsp_rise_fraction),
      .rsp_fall_fraction (rsp_fall_fraction),
      .rsp_turn_fraction (rsp_turn_fraction),
      .rsp_window_fill   (rsp_window_fill)
   );

endmodule
